[design/c8_pkg.sv]
// ----------------------------------------------------------------------------
// c8_pkg
// shared constants, types and helpers of the chip8 core
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MEM_BYTES     = 4096;
  localparam int ADDR_W        = 12;
  localparam int SCREEN_W      = 64;
  localparam int SCREEN_H      = 32;
  localparam int ROW_W         = 5;
  localparam int COL_W         = 6;
  localparam int STACK_DEPTH   = 16;
  localparam int TICK_W        = 32;
  localparam int RATE_W        = 16;
  localparam logic [ADDR_W-1:0] PROGRAM_START = 12'h200;
  localparam logic [4:0]  NO_KEY     = 5'd16;
  localparam logic [15:0] RATE_RESET = 16'd8;
  localparam logic [6:0]  RAND_DIV_LAST = 7'd99;

  // item kinds carried in tuser
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDX  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  // low byte codes
  localparam logic [7:0] LO_CLS  = 8'hE0;
  localparam logic [7:0] LO_RET  = 8'hEE;
  localparam logic [7:0] LO_SKP  = 8'h9E;
  localparam logic [7:0] LO_SKNP = 8'hA1;
  localparam logic [7:0] LO_GDT  = 8'h07;
  localparam logic [7:0] LO_WKEY = 8'h0A;
  localparam logic [7:0] LO_SDT  = 8'h15;
  localparam logic [7:0] LO_SST  = 8'h18;
  localparam logic [7:0] LO_ADDX = 8'h1E;
  localparam logic [7:0] LO_FONT = 8'h29;
  localparam logic [7:0] LO_BCD  = 8'h33;
  localparam logic [7:0] LO_STR  = 8'h55;
  localparam logic [7:0] LO_LDR  = 8'h65;

  // alu sub-ops
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [3:0] REG_F = 4'hF;

  typedef enum logic [4:0] {
    S_IDLE, S_MWR, S_PIX, S_DIV, S_TMR, S_F0, S_F1, S_F2, S_RX, S_RY,
    S_EXEC, S_DR0, S_DR1, S_DR2, S_BCD, S_ST, S_LD0, S_LD1, S_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [TICK_W-1:0]   dividend;
    logic [RATE_W-1:0]   divisor;
  } div_req_t;

  // decimal digit of an 8-bit value, digit 0 = hundreds
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = 7'(v - 8'(h * 7'd100));
    p = 15'(r) * 15'd205;
    t = p[14:11];
    unique case (sel)
      2'd0:    bcd_digit = {6'd0, h};
      2'd1:    bcd_digit = {4'd0, t};
      default: bcd_digit = {1'b0, 7'(r - 7'(t * 4'd10))};
    endcase
  endfunction

endpackage

[design/c8_ram.sv]
// ----------------------------------------------------------------------------
// c8_ram
// simple dual-port memory, one write and one registered read port
// ----------------------------------------------------------------------------
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/c8_mod.sv]
// ----------------------------------------------------------------------------
// c8_mod
// serial remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module c8_mod
  import c8_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  div_req_t          req,
  output logic              done,
  output logic [RATE_W-1:0] rem
);

  logic [TICK_W-1:0]         dq;
  logic [RATE_W-1:0]         dvs;
  logic [$clog2(TICK_W)-1:0] cnt;
  logic                      busy;
  logic [RATE_W:0]           trial;

  assign trial = {rem, dq[TICK_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        dq <= {dq[TICK_W-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= RATE_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[RATE_W-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/chip8_cpu_core.sv]
// ----------------------------------------------------------------------------
// chip8_cpu_core
// chip8 processor with 4 KiB program memory and a 64x32 xor framebuffer
// ----------------------------------------------------------------------------
// One item is taken at a time. A tick first runs the serial remainder unit
// that decides the timer decrement (skipped when timer_rate is 0), then,
// unless halted or waiting for a key, fetches, reads VX/VY and executes; a
// sprite draw then handles each row in turn (program memory read, framebuffer
// row read, row write), FX55 stores one register per step, FX65 reads then
// loads each register, FX33 writes three digits. The framebuffer is stored as
// 32 rows of 64 bits with a valid bit per row, so reset and 00E0 clear it at once.
module chip8_cpu_core
  import c8_pkg::*;
#(
  parameter int STACK_DEPTH = c8_pkg::STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // key_present, key_code, address, data_byte, pixel_x, pixel_y
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // pc, halted, awaiting_key, sound_on, pixel_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int SP_W = $clog2(STACK_DEPTH);

  state_t state, state_next;

  // captured item
  logic [1:0]        kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        data_r;
  logic [COL_W-1:0]  px_r;
  logic [ROW_W-1:0]  py_r;
  logic              snd_r;

  // architectural state
  logic [ADDR_W-1:0] pc, ireg;
  logic [SP_W-1:0]   sp;
  logic [7:0]        dly, snd;
  logic [TICK_W-1:0] tick;
  logic [7:0]        q100;
  logic [6:0]        r100;
  logic [4:0]        held;
  logic              wait_f, halt_f;
  logic [3:0]        wait_t;
  logic [RATE_W-1:0] rate;
  logic [7:0]        vreg [16];
  logic [ADDR_W-1:0] stack [STACK_DEPTH];
  logic [SCREEN_H-1:0] fb_valid;

  // work registers
  logic [7:0] hi, lo, vx, vy, spr;
  logic [3:0] cnt;
  logic       coll;

  // decode
  logic [3:0] op, rx, ry, nn;
  logic [ADDR_W-1:0] nnn;
  assign op  = hi[7:4];
  assign rx  = hi[3:0];
  assign ry  = lo[7:4];
  assign nn  = lo[3:0];
  assign nnn = {hi[3:0], lo};

  logic              accept;
  logic [SP_W-1:0]   sp_inc, sp_dec;
  logic [ADDR_W-1:0] pc2, pc4, icnt;
  assign accept = s_tvalid && s_tready;
  assign sp_inc = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;
  assign pc2    = pc + 12'd2;
  assign pc4    = pc + 12'd4;
  assign icnt   = ireg + {8'd0, cnt};

  // memories and helpers
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              fb_we, fb_re;
  logic [ROW_W-1:0]  fb_addr;
  logic [SCREEN_W-1:0] fb_wdata, fb_rdata;
  logic [3:0]        vrd_idx;
  logic [7:0]        vrd;
  div_req_t          div_req;
  logic              div_done;
  logic [RATE_W-1:0] div_rem;

  assign vrd = vreg[vrd_idx];

  c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_addr), .wdata(fb_wdata),
    .re(fb_re), .raddr(fb_addr), .rdata(fb_rdata)
  );

  c8_mod u_mod (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .rem(div_rem)
  );

  // sprite row placed on the screen row with wraparound
  logic [ROW_W-1:0]    row;
  logic [SCREEN_W-1:0] smask, old_row;
  logic [2*SCREEN_W-1:0] dbl;
  logic [SCREEN_W-1:0] spr64;
  assign row = vy[ROW_W-1:0] + ROW_W'(cnt);
  always_comb begin
    spr64 = '0;
    for (int c = 0; c < 8; c++) begin
      spr64[c] = spr[7-c];
    end
    dbl   = {spr64, spr64} << vx[COL_W-1:0];
    smask = dbl[2*SCREEN_W-1:SCREEN_W];
  end
  assign old_row = fb_valid[row] ? fb_rdata : '0;

  // flag-setting alu ops, flag written before the result register
  logic       alu_f;
  logic [7:0] vxp, alu_res;
  always_comb begin
    logic [8:0] sum;
    sum = {1'b0, vx} + {1'b0, vy};
    unique case (nn)
      ALU_ADD: alu_f = sum[8];
      ALU_SUB: alu_f = (vx >= vy);
      ALU_SHR: alu_f = vx[0];
      ALU_SBN: alu_f = (vy >= vx);
      default: alu_f = vy[7];
    endcase
    vxp = (rx == REG_F) ? {7'd0, alu_f} : vx;
    unique case (nn)
      ALU_MOV: alu_res = vy;
      ALU_OR:  alu_res = vx | vy;
      ALU_AND: alu_res = vx & vy;
      ALU_XOR: alu_res = vx ^ vy;
      ALU_ADD: alu_res = vxp + vy;
      ALU_SUB: alu_res = vxp - vy;
      ALU_SHR: alu_res = vxp >> 1;
      ALU_SBN: alu_res = vy - vxp;
      default: alu_res = {vy[6:0], 1'b0};
    endcase
  end

  logic alu_ok;
  assign alu_ok = (nn <= ALU_SBN) || (nn == ALU_SHL);

  logic out_free;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority case (s_tuser)
            KIND_TICK:  state_next = (rate != '0) ? S_DIV : S_TMR;
            KIND_WRITE: state_next = S_MWR;
            KIND_READ:  state_next = S_PIX;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_MWR, S_PIX: state_next = S_DONE;
      S_DIV: if (div_done) state_next = S_TMR;
      S_TMR: state_next = (wait_f || halt_f) ? S_DONE : S_F0;
      S_F0: state_next = S_F1;
      S_F1: state_next = S_F2;
      S_F2: state_next = S_RX;
      S_RX: state_next = S_RY;
      S_RY: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_DRW && nn != 4'd0) begin
          state_next = S_DR0;
        end else if (op == OP_MISC && lo == LO_BCD) begin
          state_next = S_BCD;
        end else if (op == OP_MISC && lo == LO_STR) begin
          state_next = S_ST;
        end else if (op == OP_MISC && lo == LO_LDR) begin
          state_next = S_LD0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DR0: state_next = S_DR1;
      S_DR1: state_next = S_DR2;
      S_DR2: state_next = (cnt == nn - 4'd1) ? S_DONE : S_DR0;
      S_BCD: if (cnt == 4'd2) state_next = S_DONE;
      S_ST:  if (cnt == rx) state_next = S_DONE;
      S_LD0: state_next = S_LD1;
      S_LD1: state_next = (cnt == rx) ? S_DONE : S_LD0;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = icnt;
    mem_raddr = icnt;
    mem_wdata = vrd;
    fb_we     = 1'b0;
    fb_re     = 1'b0;
    fb_addr   = row;
    fb_wdata  = old_row ^ smask;
    vrd_idx   = cnt;
    div_req.start    = 1'b0;
    div_req.dividend = tick + 1'b1;
    div_req.divisor  = rate;
    unique case (state)
      S_IDLE: div_req.start = accept && (s_tuser == KIND_TICK) && (rate != '0);
      S_MWR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = data_r;
      end
      S_PIX: begin
        fb_re   = 1'b1;
        fb_addr = py_r;
      end
      S_F0: begin
        mem_re    = 1'b1;
        mem_raddr = pc;
      end
      S_F1: begin
        mem_re    = 1'b1;
        mem_raddr = pc + 12'd1;
      end
      S_RX: vrd_idx = (op == OP_JPV) ? 4'd0 : rx;
      S_RY: vrd_idx = ry;
      S_DR0, S_LD0: mem_re = 1'b1;
      S_DR1: fb_re = 1'b1;
      S_DR2: fb_we = 1'b1;
      S_BCD: begin
        mem_we    = 1'b1;
        mem_wdata = bcd_digit(vx, cnt[1:0]);
      end
      S_ST: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pc       <= PROGRAM_START;
      ireg     <= PROGRAM_START;
      sp       <= '0;
      dly      <= '0;
      snd      <= '0;
      tick     <= '0;
      q100     <= '0;
      r100     <= '0;
      held     <= NO_KEY;
      wait_f   <= 1'b0;
      wait_t   <= '0;
      halt_f   <= 1'b0;
      rate     <= RATE_RESET;
      fb_valid <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        vreg[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        rate <= cfg_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r <= s_tuser;
            addr_r <= s_tdata[16:5];
            data_r <= s_tdata[24:17];
            px_r   <= s_tdata[30:25];
            py_r   <= s_tdata[35:31];
            snd_r  <= (snd != '0);
            if (s_tuser == KIND_TICK) begin
              tick <= tick + 1'b1;
              if (r100 == RAND_DIV_LAST) begin
                r100 <= '0;
                q100 <= q100 + 1'b1;
              end else begin
                r100 <= r100 + 1'b1;
              end
              if (s_tdata[0]) begin
                held <= {1'b0, s_tdata[4:1]};
              end
            end
          end
        end
        S_TMR: begin
          if (rate != '0 && div_rem == '0) begin
            if (snd != '0) snd <= snd - 1'b1;
            if (dly != '0) dly <= dly - 1'b1;
          end
          if (wait_f && held != NO_KEY) begin
            vreg[wait_t] <= {4'd0, held[3:0]};
            wait_f       <= 1'b0;
          end
        end
        S_F1: hi <= mem_rdata;
        S_F2: lo <= mem_rdata;
        S_RX: vx <= vrd;
        S_RY: vy <= vrd;
        S_EXEC: begin
          cnt  <= '0;
          coll <= 1'b0;
          unique case (op)
            OP_SYS: begin
              if (hi == 8'h00 && lo == LO_CLS) begin
                fb_valid <= '0;
                pc       <= pc2;
              end else if (hi == 8'h00 && lo == LO_RET) begin
                sp <= sp_dec;
                pc <= stack[sp_dec];
              end else begin
                halt_f <= 1'b1;
              end
            end
            OP_JP: pc <= nnn;
            OP_CALL: begin
              stack[sp] <= pc2;
              sp        <= sp_inc;
              pc        <= nnn;
            end
            OP_SEI:  pc <= (vx == lo) ? pc4 : pc2;
            OP_SNEI: pc <= (vx != lo) ? pc4 : pc2;
            OP_SER, OP_SNER: begin
              if (nn != 4'd0) begin
                halt_f <= 1'b1;
              end else begin
                pc <= (((vx == vy) ? 1'b1 : 1'b0) == (op == OP_SER)) ? pc4 : pc2;
              end
            end
            OP_LDI: begin
              vreg[rx] <= lo;
              pc       <= pc2;
            end
            OP_ADDI: begin
              vreg[rx] <= vx + lo;
              pc       <= pc2;
            end
            OP_ALU: begin
              if (!alu_ok) begin
                halt_f <= 1'b1;
              end else begin
                if (nn >= ALU_ADD) begin
                  vreg[REG_F] <= {7'd0, alu_f};
                end
                vreg[rx] <= alu_res;
                pc       <= pc2;
              end
            end
            OP_LDX: begin
              ireg <= nnn;
              pc   <= pc2;
            end
            OP_JPV: pc <= nnn + {4'd0, vx};
            OP_RND: begin
              vreg[rx] <= q100 & lo;
              pc       <= pc2;
            end
            OP_DRW: begin
              if (nn == 4'd0) begin
                vreg[REG_F] <= '0;
                pc          <= pc2;
              end
            end
            OP_KEY: begin
              if (lo == LO_SKP) begin
                if (held == {1'b0, vx[3:0]} && vx[7:4] == 4'd0) begin
                  pc   <= pc4;
                  held <= NO_KEY;
                end else begin
                  pc <= pc2;
                end
              end else if (lo == LO_SKNP) begin
                if (held != {1'b0, vx[3:0]} || vx[7:4] != 4'd0) begin
                  pc <= pc4;
                end else begin
                  pc   <= pc2;
                  held <= NO_KEY;
                end
              end else begin
                halt_f <= 1'b1;
              end
            end
            default: begin
              priority case (lo)
                LO_GDT: begin
                  vreg[rx] <= dly;
                  pc       <= pc2;
                end
                LO_WKEY: begin
                  wait_t <= rx;
                  wait_f <= 1'b1;
                  pc     <= pc2;
                end
                LO_SDT: begin
                  dly <= vx;
                  pc  <= pc2;
                end
                LO_SST: begin
                  snd <= vx;
                  pc  <= pc2;
                end
                LO_ADDX: begin
                  ireg <= ireg + {4'd0, vx};
                  pc   <= pc2;
                end
                LO_FONT: begin
                  ireg <= {1'b0, ({3'd0, vx} << 2) + {3'd0, vx}};
                  pc   <= pc2;
                end
                LO_BCD, LO_STR, LO_LDR: ;
                default: halt_f <= 1'b1;
              endcase
            end
          endcase
        end
        S_DR1: spr <= mem_rdata;
        S_DR2: begin
          fb_valid[row] <= 1'b1;
          if (cnt == nn - 4'd1) begin
            vreg[REG_F] <= {7'd0, coll | (|(old_row & smask))};
            pc          <= pc2;
          end else begin
            coll <= coll | (|(old_row & smask));
            cnt  <= cnt + 1'b1;
          end
        end
        S_BCD: begin
          cnt <= cnt + 1'b1;
          if (cnt == 4'd2) pc <= pc2;
        end
        S_ST: begin
          cnt <= cnt + 1'b1;
          if (cnt == rx) begin
            ireg <= ireg + {8'd0, rx} + 12'd1;
            pc   <= pc2;
          end
        end
        S_LD1: begin
          vreg[cnt] <= mem_rdata;
          cnt       <= cnt + 1'b1;
          if (cnt == rx) begin
            ireg <= ireg + {8'd0, rx} + 12'd1;
            pc   <= pc2;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(kind_r == KIND_READ) && fb_valid[py_r] && fb_rdata[px_r],
                         snd_r, wait_f, halt_f, pc};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[design/c8_chk.sv]
// ----------------------------------------------------------------------------
// c8_chk
// port-level checks of the chip8 core, bound to the top level
// ----------------------------------------------------------------------------
module c8_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  logic seen_halt;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[12]) begin
      seen_halt <= 1'b1;
    end
  end

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && seen_halt |-> m_tdata[12])
    else $error("halt flag dropped");

  // a waiting core never halts
  a_wait_halt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
    else $error("halted while awaiting key");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind chip8_cpu_core c8_chk u_c8_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[sim/tb_chip8_cpu_core.sv]
// ----------------------------------------------------------------------------
// tb_chip8_cpu_core
// self-checking bench for the chip8 core: a behavioral mirror of the machine
// predicts the status word of every item, items and results are throttled
// at random, and every status word is compared field by field
// ----------------------------------------------------------------------------
class chip8_mirror;

  bit [7:0]  mem [c8_pkg::MEM_BYTES];
  bit        pix [c8_pkg::SCREEN_W * c8_pkg::SCREEN_H];
  bit [7:0]  v [16];
  bit [11:0] ir, pc;
  bit [11:0] stk [c8_pkg::STACK_DEPTH];
  bit        stk_ok [c8_pkg::STACK_DEPTH];
  int        sp;
  bit [7:0]  dly, snd;
  bit [31:0] ticks;
  bit [4:0]  key;
  bit        waiting, halt;
  bit [3:0]  wreg;
  bit [15:0] rate;
  bit [15:0] status_q [$];
  int        errors;

  function new();
    pc = c8_pkg::PROGRAM_START;
    ir = c8_pkg::PROGRAM_START;
    key = c8_pkg::NO_KEY;
    rate = c8_pkg::RATE_RESET;
  endfunction

  function void report(string what, int got, int want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endfunction

  // opcodes that would halt the core, or a return into a never-written slot
  function bit would_stop(bit [7:0] hi, bit [7:0] lo);
    bit [3:0] n;
    n = lo[3:0];
    case (hi[7:4])
      c8_pkg::OP_SYS: begin
        if (hi == 8'h00 && lo == c8_pkg::LO_CLS) return 0;
        if (hi == 8'h00 && lo == c8_pkg::LO_RET)
          return !stk_ok[(sp + c8_pkg::STACK_DEPTH - 1) % c8_pkg::STACK_DEPTH];
        return 1;
      end
      c8_pkg::OP_SER, c8_pkg::OP_SNER: return n != 0;
      c8_pkg::OP_ALU: return !(n inside {c8_pkg::ALU_MOV, c8_pkg::ALU_OR, c8_pkg::ALU_AND,
        c8_pkg::ALU_XOR, c8_pkg::ALU_ADD, c8_pkg::ALU_SUB, c8_pkg::ALU_SHR,
        c8_pkg::ALU_SBN, c8_pkg::ALU_SHL});
      c8_pkg::OP_KEY: return !(lo inside {c8_pkg::LO_SKP, c8_pkg::LO_SKNP});
      c8_pkg::OP_MISC: return !(lo inside {c8_pkg::LO_GDT, c8_pkg::LO_WKEY, c8_pkg::LO_SDT,
        c8_pkg::LO_SST, c8_pkg::LO_ADDX, c8_pkg::LO_FONT, c8_pkg::LO_BCD,
        c8_pkg::LO_STR, c8_pkg::LO_LDR});
      default: return 0;
    endcase
  endfunction

  function void run_op();
    bit [7:0]  hi, lo, vx, vy, row;
    bit [3:0]  x, y, n;
    bit [11:0] nnn;
    int        k;
    hi = mem[pc]; lo = mem[12'(pc + 1)];
    x = hi[3:0]; y = lo[7:4]; n = lo[3:0];
    nnn = {hi[3:0], lo};
    vx = v[x]; vy = v[y];
    case (hi[7:4])
      c8_pkg::OP_SYS: begin
        if (hi == 8'h00 && lo == c8_pkg::LO_CLS) begin
          foreach (pix[i]) pix[i] = 0;
          pc += 2;
        end else if (hi == 8'h00 && lo == c8_pkg::LO_RET) begin
          sp = (sp + c8_pkg::STACK_DEPTH - 1) % c8_pkg::STACK_DEPTH;
          pc = stk[sp];
        end else halt = 1;
      end
      c8_pkg::OP_JP: pc = nnn;
      c8_pkg::OP_CALL: begin
        stk[sp] = pc + 2; stk_ok[sp] = 1;
        sp = (sp + 1) % c8_pkg::STACK_DEPTH;
        pc = nnn;
      end
      c8_pkg::OP_SEI: pc += (vx == lo) ? 4 : 2;
      c8_pkg::OP_SNEI: pc += (vx != lo) ? 4 : 2;
      c8_pkg::OP_SER, c8_pkg::OP_SNER: begin
        if (n != 0) halt = 1;
        else pc += (((vx == vy) == (hi[7:4] == c8_pkg::OP_SER)) ? 4 : 2);
      end
      c8_pkg::OP_LDI: begin v[x] = lo; pc += 2; end
      c8_pkg::OP_ADDI: begin v[x] = vx + lo; pc += 2; end
      c8_pkg::OP_ALU: begin
        case (n)
          c8_pkg::ALU_MOV: v[x] = vy;
          c8_pkg::ALU_OR:  v[x] = vx | vy;
          c8_pkg::ALU_AND: v[x] = vx & vy;
          c8_pkg::ALU_XOR: v[x] = vx ^ vy;
          c8_pkg::ALU_ADD: begin v[c8_pkg::REG_F] = (9'(vx) + vy) > 255; v[x] = v[x] + vy; end
          c8_pkg::ALU_SUB: begin v[c8_pkg::REG_F] = !(vx < vy); v[x] = v[x] - vy; end
          c8_pkg::ALU_SHR: begin v[c8_pkg::REG_F] = vx[0]; v[x] = v[x] >> 1; end
          c8_pkg::ALU_SBN: begin v[c8_pkg::REG_F] = !(vy < vx); v[x] = vy - v[x]; end
          c8_pkg::ALU_SHL: begin v[c8_pkg::REG_F] = vy[7]; v[x] = vy << 1; end
          default: halt = 1;
        endcase
        if (!halt) pc += 2;
      end
      c8_pkg::OP_LDX: begin ir = nnn; pc += 2; end
      c8_pkg::OP_JPV: pc = nnn + v[0];
      c8_pkg::OP_RND: begin v[x] = 8'(ticks / 100) & lo; pc += 2; end
      c8_pkg::OP_DRW: begin
        // coordinates are taken before the flag register is cleared
        v[c8_pkg::REG_F] = 0;
        for (int r = 0; r < n; r++) begin
          row = mem[12'(ir + r)];
          for (int c = 0; c < 8; c++) if (row[7-c]) begin
            k = ((vy + r) % c8_pkg::SCREEN_H) * c8_pkg::SCREEN_W + (vx + c) % c8_pkg::SCREEN_W;
            if (pix[k]) v[c8_pkg::REG_F] = 1;
            pix[k] ^= 1;
          end
        end
        pc += 2;
      end
      c8_pkg::OP_KEY: begin
        if (lo == c8_pkg::LO_SKP) begin
          if (key == {1'b0, vx} && vx < 16) begin pc += 4; key = c8_pkg::NO_KEY; end
          else pc += 2;
        end else if (lo == c8_pkg::LO_SKNP) begin
          if (!(key == {1'b0, vx} && vx < 16)) pc += 4;
          else begin pc += 2; key = c8_pkg::NO_KEY; end
        end else halt = 1;
      end
      default: begin
        case (lo)
          c8_pkg::LO_GDT:  v[x] = dly;
          c8_pkg::LO_WKEY: begin wreg = x; waiting = 1; end
          c8_pkg::LO_SDT:  dly = vx;
          c8_pkg::LO_SST:  snd = vx;
          c8_pkg::LO_ADDX: ir = ir + vx;
          c8_pkg::LO_FONT: ir = 12'(vx * 5);
          c8_pkg::LO_BCD: begin
            mem[ir] = vx / 100;
            mem[12'(ir + 1)] = (vx % 100) / 10;
            mem[12'(ir + 2)] = vx % 10;
          end
          c8_pkg::LO_STR: begin
            for (int c = 0; c <= x; c++) mem[12'(ir + c)] = v[c];
            ir = ir + x + 1;
          end
          c8_pkg::LO_LDR: begin
            for (int c = 0; c <= x; c++) v[c] = mem[12'(ir + c)];
            ir = ir + x + 1;
          end
          default: halt = 1;
        endcase
        if (!halt) pc += 2;
      end
    endcase
  endfunction

  function void accept_item(bit [1:0] kind, bit [39:0] d);
    bit s, p;
    p = 0;
    if (kind == c8_pkg::KIND_TICK) begin
      ticks++;
      if (d[0]) key = {1'b0, d[4:1]};
      s = snd != 0;
      if (rate != 0 && ticks % rate == 0) begin
        if (snd > 0) snd--;
        if (dly > 0) dly--;
      end
      if (waiting) begin
        if (key != c8_pkg::NO_KEY) begin v[wreg] = key; waiting = 0; end
      end else if (!halt) run_op();
    end else begin
      if (kind == c8_pkg::KIND_WRITE) mem[d[16:5]] = d[24:17];
      else if (kind == c8_pkg::KIND_READ) p = pix[d[35:31] * c8_pkg::SCREEN_W + d[30:25]];
      s = snd != 0;
    end
    status_q.push_back({p, s, waiting, halt, pc});
  endfunction

  function void check_status(bit [15:0] got);
    bit [15:0] want;
    if (status_q.size() == 0) begin
      report("unexpected result", got, 0);
      return;
    end
    want = status_q.pop_front();
    if (got[11:0] != want[11:0]) report("pc", got[11:0], want[11:0]);
    if (got[12] != want[12]) report("halted", got[12], want[12]);
    if (got[13] != want[13]) report("awaiting_key", got[13], want[13]);
    if (got[14] != want[14]) report("sound_on", got[14], want[14]);
    if (got[15] != want[15]) report("pixel_value", got[15], want[15]);
  endfunction

endclass

module tb_chip8_cpu_core;
  import c8_pkg::*;

  localparam int LIMIT = 3_000_000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_TICK;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  chip8_mirror mirror = new();
  bit          calm;
  int          stall_left;
  int          cycles;

  chip8_cpu_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: sample, then pick readiness for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_status(m_tdata);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 0;
    end else if (calm || $urandom_range(0, 9) < 7) m_tready <= 1;
    else begin
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
      m_tready <= 0;
    end
  end

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(20, 60);
  endfunction

  task automatic send(bit [1:0] kind, bit [39:0] d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    mirror.accept_item(kind, d);
  endtask

  function automatic bit [39:0] rand_fields();
    return {4'd0, 36'({$urandom(), $urandom_range(0, 15)})};
  endfunction

  task automatic poke(bit [11:0] addr, bit [7:0] val);
    bit [39:0] d;
    d = rand_fields();
    d[16:5] = addr;
    d[24:17] = val;
    send(KIND_WRITE, d);
  endtask

  task automatic poke_word(bit [11:0] addr, bit [15:0] w);
    poke(addr, w[15:8]);
    poke(addr + 12'd1, w[7:0]);
  endtask

  function automatic bit [15:0] pick_op();
    bit [15:0] w;
    int        sel;
    bit [7:0]  misc [9];
    misc = '{LO_GDT, LO_WKEY, LO_SDT, LO_SST, LO_ADDX, LO_FONT, LO_BCD, LO_STR, LO_LDR};
    do begin
      w = $urandom();
      sel = $urandom_range(0, 9);
      if (sel == 0) w = {8'h00, ($urandom_range(0, 1) ? LO_RET : LO_CLS)};
      else if (sel == 1) w = {OP_MISC, w[11:8], misc[$urandom_range(0, 8)]};
      else if (sel == 2) w = {OP_DRW, w[11:4], 4'($urandom_range(0, 4))};
      else if (sel == 3) w = {OP_KEY, w[11:8], ($urandom_range(0, 1) ? LO_SKP : LO_SKNP)};
    end while (mirror.would_stop(w[15:8], w[7:0]));
    return w;
  endfunction

  // a tick, after repairing the instruction at pc if it would halt the core (unless keep_halts)
  task automatic tick(bit keep_halts = 0);
    bit [39:0] d;
    if (!keep_halts && !mirror.halt && !mirror.waiting &&
        mirror.would_stop(mirror.mem[mirror.pc], mirror.mem[12'(mirror.pc + 1)]))
      poke_word(mirror.pc, pick_op());
    d = rand_fields();
    d[0] = ($urandom_range(0, 9) < 3);
    send(KIND_TICK, d);
  endtask

  task automatic set_rate(bit [15:0] r);
    s_tvalid <= 0;
    while (mirror.status_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    mirror.rate = r;
  endtask

  bit [15:0] boot [] = '{
    16'h00E0, 16'h60FF, 16'h6101, 16'h8014, 16'h8106, 16'h820E, 16'hF029,
    16'hD015, 16'hD015, 16'hC3FF, 16'hF318, 16'h6405, 16'hF40A, 16'hE49E,
    16'h1234, 16'hE4A1, 16'hF533, 16'h2300
  };
  bit [15:0] rates [] = '{16'd1, 16'd65535, 16'd0, 16'd8};

  initial begin
    bit [39:0] d;
    int        r;
    repeat (2) @(posedge clk);
    rst <= 0;
    set_rate(16'd3);
    // every memory byte gets defined before anything can fetch it
    calm = 1;
    for (int a = 0; a < MEM_BYTES; a++) poke(a, $urandom());
    calm = 0;
    foreach (boot[i]) poke_word(PROGRAM_START + 2 * i, boot[i]);
    poke_word(12'h300, {8'h00, LO_RET});
    foreach (boot[i]) begin
      d = rand_fields();
      // a key press lands while the wait-for-key is pending
      d[0] = (i == 13);
      d[4:1] = 4'd5;
      send(KIND_TICK, d);
    end
    repeat (3) tick();
    for (int y = 0; y < 3; y++) begin
      d = rand_fields();
      d[30:25] = y;
      d[35:31] = 1 + y;
      send(KIND_READ, d);
    end
    for (int ph = 0; ph < 5; ph++) begin
      set_rate(ph < 4 ? rates[ph] : 16'($urandom_range(2, 40)));
      calm = (ph == 2);
      repeat (80) begin
        r = $urandom_range(0, 99);
        if (r < 70) tick();
        else if (r < 82) send(KIND_WRITE, rand_fields());
        else if (r < 97) send(KIND_READ, rand_fields());
        else send(2'd3, rand_fields());
      end
    end
    // machine call halts for good; timers and key latch keep running
    poke_word(mirror.pc, 16'h0123);
    repeat (4) tick(1);
    send(KIND_READ, rand_fields());
    s_tvalid <= 0;
    while (mirror.status_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mirror.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
